### rtl/pidaw_pkg.sv
package pidaw_pkg;

	// Shared multiplier: a 48-bit signed operand times a 17-bit signed operand.
	localparam int MUL_A_W = 48;
	localparam int MUL_B_W = 17;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	// Working sums are exact over everything that feeds them.
	localparam int WORK_W  = 66;
	localparam int GAIN_W  = 16;
	localparam int LIM_W   = 32;
	localparam int DRIVE_W = 16;
	localparam int STEP_W  = 4;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_FIRST = 4'd0;
	localparam step_t STEP_CLEAR = 4'd10;
	localparam step_t STEP_LAST  = 4'd10;

	typedef enum logic [1:0] {
		ACT_UPDATE  = 2'd0,
		ACT_CLR_INT = 2'd1,
		ACT_CLR_ALL = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_PROP_GAIN    = 3'd0,
		REG_INTEG_GAIN   = 3'd1,
		REG_DERIV_GAIN   = 3'd2,
		REG_UPPER_LIMIT  = 3'd3,
		REG_LOWER_LIMIT  = 3'd4,
		REG_OUTPUT_SCALE = 3'd5,
		REG_DERIV_SOURCE = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {A_ERR, A_DTERM, A_CLAMP, A_DIFF} a_sel_t;
	typedef enum logic [2:0] {B_KI, B_KP, B_KD, B_SCL_LO, B_SCL_HI} b_sel_t;
	typedef enum logic [2:0] {
		ACC_HOLD, ACC_LOAD_PI, ACC_ADD_PROD, ACC_LOAD_PROD, ACC_ADD_HI
	} acc_op_t;
	typedef enum logic [1:0] {INT_HOLD, INT_ADD_PROD, INT_ADD_CORR, INT_CLEAR} int_op_t;
	typedef enum logic {JMP_NONE, JMP_ACTION} jmp_t;

	typedef struct packed {
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		acc_op_t acc_op;
		int_op_t int_op;
		logic    ld_err;
		logic    ld_dterm;
		logic    ld_clamp;
		logic    ld_diff;
		jmp_t    jmp;
		step_t   target;
		logic    done;
		logic    res_zero;
	} ctrl_word_t;

	localparam logic signed [WORK_W-1:0] SAT64_MAX = WORK_W'(64'sh7fff_ffff_ffff_ffff);
	localparam logic signed [WORK_W-1:0] SAT64_MIN = ~SAT64_MAX;
	localparam logic signed [WORK_W-1:0] DIFF_MAX  = WORK_W'(48'sh7fff_ffff_ffff);
	localparam logic signed [WORK_W-1:0] DIFF_MIN  = ~DIFF_MAX;

	// Saturate an exact working sum to the signed 64-bit range.
	function automatic logic signed [WORK_W-1:0] sat64(input logic signed [WORK_W-1:0] v);
		logic signed [WORK_W-1:0] r;
		if (v > SAT64_MAX)
			r = SAT64_MAX;
		else if (v < SAT64_MIN)
			r = SAT64_MIN;
		else
			r = v;
		return r;
	endfunction

	// Control store. Update program runs steps 0 to 9; every other action jumps to 10.
	function automatic ctrl_word_t ucode(input step_t step);
		ctrl_word_t cw;
		cw = '0;
		case (step)
			4'd0: begin
				cw.ld_err = 1'b1;
				cw.jmp    = JMP_ACTION;
				cw.target = STEP_CLEAR;
			end
			4'd1: begin
				cw.ld_dterm = 1'b1;
				cw.a_sel    = A_ERR;
				cw.b_sel    = B_KI;
			end
			4'd2: begin
				cw.a_sel  = A_ERR;
				cw.b_sel  = B_KP;
				cw.int_op = INT_ADD_PROD;
			end
			4'd3: begin
				cw.a_sel  = A_DTERM;
				cw.b_sel  = B_KD;
				cw.acc_op = ACC_LOAD_PI;
			end
			4'd4: begin
				cw.acc_op = ACC_ADD_PROD;
			end
			4'd5: begin
				cw.ld_clamp = 1'b1;
			end
			4'd6: begin
				cw.ld_diff = 1'b1;
				cw.a_sel   = A_CLAMP;
				cw.b_sel   = B_SCL_LO;
			end
			4'd7: begin
				cw.acc_op = ACC_LOAD_PROD;
				cw.a_sel  = A_CLAMP;
				cw.b_sel  = B_SCL_HI;
			end
			4'd8: begin
				cw.acc_op = ACC_ADD_HI;
				cw.a_sel  = A_DIFF;
				cw.b_sel  = B_KI;
			end
			4'd9: begin
				cw.int_op = INT_ADD_CORR;
				cw.done   = 1'b1;
			end
			4'd10: begin
				cw.int_op   = INT_CLEAR;
				cw.done     = 1'b1;
				cw.res_zero = 1'b1;
			end
			default: begin
				cw.done     = 1'b1;
				cw.res_zero = 1'b1;
			end
		endcase
		return cw;
	endfunction

endpackage

### rtl/pid_controller_antiwindup.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: target, measured, deriv_sample
//                                                     tuser: action
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: drive, limited_output
//                                                     tuser: clamp_hit
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// An update word runs the update program before its result reaches the output register; a
// clear or ignored word jumps from step 0 to the clear step. Every product runs through one
// shared 48x17 multiplier with a register behind it. The input reopens once the result is
// parked, so no new word is taken mid-program. The last step stalls only while the previous
// result still waits on m_axis_tready. Reset loads the configuration defaults and clears
// the sequencer, the integrator and the previous error; cfg is always ready.
module pid_controller_antiwindup #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ACC_WIDTH    = 40
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_axis_tvalid,
	output logic                                        s_axis_tready,
	// target, measured, deriv_sample, from bit 0 up
	input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]          s_axis_tdata,
	// action
	input  logic [1:0]                                  s_axis_tuser,
	output logic                                        m_axis_tvalid,
	input  logic                                        m_axis_tready,
	// drive, limited_output, from bit 0 up
	output logic [pidaw_pkg::DRIVE_W+pidaw_pkg::LIM_W-1:0] m_axis_tdata,
	// clamp_hit
	output logic [0:0]                                  m_axis_tuser,
	input  logic                                        cfg_valid,
	output logic                                        cfg_ready,
	input  logic [2:0]                                  cfg_index,
	input  logic [31:0]                                 cfg_data
);
	import pidaw_pkg::*;

	localparam int SW      = SAMPLE_WIDTH;
	localparam int ERR_W   = SAMPLE_WIDTH + 1;
	localparam int DTERM_W = SAMPLE_WIDTH + 2;

	localparam logic signed [WORK_W-1:0] ACC_MAX =
		(WORK_W'(1) <<< (ACC_WIDTH - 1)) - WORK_W'(1);
	localparam logic signed [WORK_W-1:0] ACC_MIN = ~ACC_MAX;
	localparam logic signed [WORK_W-1:0] DRV_MAX = WORK_W'(16'sh7fff);
	localparam logic signed [WORK_W-1:0] DRV_MIN = ~DRV_MAX;

	// Configuration registers.
	logic signed [GAIN_W-1:0] prop_gain_q, integ_gain_q, deriv_gain_q;
	logic signed [LIM_W-1:0]  upper_q, lower_q, scale_q;
	logic                     dsrc_q;

	// Controller state.
	logic signed [ACC_WIDTH-1:0] integ_q;
	logic signed [ERR_W-1:0]     prev_err_q;

	// Sequencer.
	logic       busy_q;
	step_t      step_q;
	ctrl_word_t cw;
	logic       out_free;
	logic       adv;

	// Captured input word.
	action_t              action_q;
	logic signed [SW-1:0] target_q, measured_q, sample_q;

	// Datapath registers.
	logic signed [ERR_W-1:0]   err_q;
	logic signed [DTERM_W-1:0] dterm_q;
	logic signed [WORK_W-1:0]  acc_q;
	logic signed [LIM_W-1:0]   clamped_q;
	logic                      hit_q;
	logic signed [MUL_A_W-1:0] diff_q;
	logic signed [PROD_W-1:0]  prod_s1;

	// Output register.
	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] drive_out_q;
	logic signed [LIM_W-1:0]   lim_out_q;
	logic                      hit_out_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [WORK_W-1:0]  prod_ext, integ_ext, integ_sum, integ_sat;
	logic signed [WORK_W-1:0]  up_ext, lo_ext, diff_work, drv_shift;
	logic signed [LIM_W-1:0]   clamp_val;
	logic                      clamp_gt, clamp_lt;
	logic signed [DRIVE_W-1:0] drive_val;
	logic                      in_fire;
	logic                      jump_taken;

	assign cw         = ucode(step_q);
	assign out_free   = !out_valid_q || m_axis_tready;
	assign adv        = busy_q && (!cw.done || out_free);
	assign in_fire    = s_axis_tvalid && s_axis_tready;
	assign jump_taken = (cw.jmp == JMP_ACTION) && (action_q != ACT_UPDATE);

	assign s_axis_tready = !busy_q;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {lim_out_q, drive_out_q};
	assign m_axis_tuser  = hit_out_q;

	// Shared multiplier operand selection.
	always_comb begin
		case (cw.a_sel)
			A_ERR:   mul_a = MUL_A_W'(err_q);
			A_DTERM: mul_a = MUL_A_W'(dterm_q);
			A_CLAMP: mul_a = MUL_A_W'(clamped_q);
			A_DIFF:  mul_a = diff_q;
			default: mul_a = '0;
		endcase
		case (cw.b_sel)
			B_KI:     mul_b = MUL_B_W'(integ_gain_q);
			B_KP:     mul_b = MUL_B_W'(prop_gain_q);
			B_KD:     mul_b = MUL_B_W'(deriv_gain_q);
			B_SCL_LO: mul_b = $signed({1'b0, scale_q[15:0]});
			B_SCL_HI: mul_b = MUL_B_W'($signed(scale_q[31:16]));
			default:  mul_b = '0;
		endcase
	end

	// Integrator update, saturated to its own width.
	always_comb begin
		prod_ext  = WORK_W'(prod_s1);
		integ_ext = WORK_W'(integ_q);
		if (cw.int_op == INT_ADD_CORR)
			integ_sum = integ_ext + (prod_ext >>> 8);
		else
			integ_sum = integ_ext + prod_ext;
		if (integ_sum > ACC_MAX)
			integ_sat = ACC_MAX;
		else if (integ_sum < ACC_MIN)
			integ_sat = ACC_MIN;
		else
			integ_sat = integ_sum;
	end

	// Output clamp; the upper limit wins when a value breaks both limits.
	always_comb begin
		up_ext   = WORK_W'(upper_q);
		lo_ext   = WORK_W'(lower_q);
		clamp_gt = acc_q > up_ext;
		clamp_lt = acc_q < lo_ext;
		if (clamp_gt)
			clamp_val = upper_q;
		else if (clamp_lt)
			clamp_val = lower_q;
		else
			clamp_val = acc_q[LIM_W-1:0];
		diff_work = WORK_W'(clamped_q) - acc_q;
		if (diff_work > DIFF_MAX)
			diff_work = DIFF_MAX;
		else if (diff_work < DIFF_MIN)
			diff_work = DIFF_MIN;
	end

	// Drive: floor of the Q24 product, saturated to 16 bits.
	always_comb begin
		drv_shift = acc_q >>> 24;
		if (drv_shift > DRV_MAX)
			drive_val = 16'sh7fff;
		else if (drv_shift < DRV_MIN)
			drive_val = 16'sh8000;
		else
			drive_val = drv_shift[DRIVE_W-1:0];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= '0;
			integ_gain_q <= '0;
			deriv_gain_q <= '0;
			upper_q      <= 32'sh7fff_ffff;
			lower_q      <= 32'sh8000_0000;
			scale_q      <= 32'sh0001_0000;
			dsrc_q       <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_PROP_GAIN:    prop_gain_q  <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN:   integ_gain_q <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:   deriv_gain_q <= cfg_data[GAIN_W-1:0];
				REG_UPPER_LIMIT:  upper_q      <= cfg_data;
				REG_LOWER_LIMIT:  lower_q      <= cfg_data;
				REG_OUTPUT_SCALE: scale_q      <= cfg_data;
				REG_DERIV_SOURCE: dsrc_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= STEP_FIRST;
			out_valid_q <= 1'b0;
			integ_q     <= '0;
			prev_err_q  <= '0;
		end else begin
			if (in_fire) begin
				busy_q <= 1'b1;
				step_q <= STEP_FIRST;
			end else if (adv) begin
				if (cw.done) begin
					busy_q <= 1'b0;
					step_q <= STEP_FIRST;
				end else if (jump_taken) begin
					step_q <= cw.target;
				end else begin
					step_q <= step_q + step_t'(1);
				end
			end

			if (adv && cw.done)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;

			if (adv) begin
				case (cw.int_op)
					INT_ADD_PROD: integ_q <= integ_sat[ACC_WIDTH-1:0];
					INT_ADD_CORR: if (hit_q) integ_q <= integ_sat[ACC_WIDTH-1:0];
					INT_CLEAR: begin
						if (action_q == ACT_CLR_INT || action_q == ACT_CLR_ALL)
							integ_q <= '0;
						if (action_q == ACT_CLR_ALL)
							prev_err_q <= '0;
					end
					default: ;
				endcase
				if (cw.ld_dterm && !dsrc_q)
					prev_err_q <= err_q;
			end
		end
	end

	// Datapath and payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_q   <= action_t'(s_axis_tuser);
			target_q   <= s_axis_tdata[SW-1:0];
			measured_q <= s_axis_tdata[2*SW-1:SW];
			sample_q   <= s_axis_tdata[3*SW-1:2*SW];
		end
		if (adv) begin
			prod_s1 <= mul_a * mul_b;
			if (cw.ld_err)
				err_q <= ERR_W'(target_q) - ERR_W'(measured_q);
			if (cw.ld_dterm) begin
				if (dsrc_q)
					dterm_q <= DTERM_W'(sample_q);
				else
					dterm_q <= DTERM_W'(err_q) - DTERM_W'(prev_err_q);
			end
			case (cw.acc_op)
				ACC_LOAD_PI:   acc_q <= sat64(prod_ext + integ_ext);
				ACC_ADD_PROD:  acc_q <= sat64(acc_q + prod_ext);
				ACC_LOAD_PROD: acc_q <= prod_ext;
				ACC_ADD_HI:    acc_q <= acc_q + (prod_ext <<< 16);
				default: ;
			endcase
			if (cw.ld_clamp) begin
				clamped_q <= clamp_val;
				hit_q     <= clamp_gt || clamp_lt;
			end
			if (cw.ld_diff)
				diff_q <= diff_work[MUL_A_W-1:0];
			if (cw.done) begin
				if (cw.res_zero) begin
					drive_out_q <= '0;
					lim_out_q   <= '0;
					hit_out_q   <= 1'b0;
				end else begin
					drive_out_q <= drive_val;
					lim_out_q   <= clamped_q;
					hit_out_q   <= hit_q;
				end
			end
		end
	end

	// A word taken in starts the program at its first step.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> busy_q && step_q == STEP_FIRST)
		else $error("program did not start on an accepted word");

	// The last step of the program always lands its result in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && cw.done |=> m_axis_tvalid && !busy_q)
		else $error("finished program left no result");

	// A stalled last step holds its place.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !adv |=> busy_q && $stable(step_q))
		else $error("sequencer moved while stalled");

	// The step counter never leaves the program.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= STEP_LAST)
		else $error("step counter out of program");

endmodule
